@@ hw/rtl/hrp_pkg.sv @@
// shared types, codes and byte-class helpers for the http request head parser
// no dependencies; imported by hrp_core, http_request_head_parser and its testbench
`default_nettype none

package hrp_pkg;

    localparam int PHASE_W = 5;

    // parser phases
    localparam logic [PHASE_W-1:0] PH_METHOD_START = 5'd0;
    localparam logic [PHASE_W-1:0] PH_METHOD       = 5'd1;
    localparam logic [PHASE_W-1:0] PH_URI          = 5'd2;
    localparam logic [PHASE_W-1:0] PH_VER_H        = 5'd3;
    localparam logic [PHASE_W-1:0] PH_VER_T1       = 5'd4;
    localparam logic [PHASE_W-1:0] PH_VER_T2       = 5'd5;
    localparam logic [PHASE_W-1:0] PH_VER_P        = 5'd6;
    localparam logic [PHASE_W-1:0] PH_VER_SLASH    = 5'd7;
    localparam logic [PHASE_W-1:0] PH_MAJOR_START  = 5'd8;
    localparam logic [PHASE_W-1:0] PH_MAJOR        = 5'd9;
    localparam logic [PHASE_W-1:0] PH_MINOR_START  = 5'd10;
    localparam logic [PHASE_W-1:0] PH_MINOR        = 5'd11;
    localparam logic [PHASE_W-1:0] PH_LF1          = 5'd12;
    localparam logic [PHASE_W-1:0] PH_LINE_START   = 5'd13;
    localparam logic [PHASE_W-1:0] PH_LWS          = 5'd14;
    localparam logic [PHASE_W-1:0] PH_NAME         = 5'd15;
    localparam logic [PHASE_W-1:0] PH_SPACE_BEFORE = 5'd16;
    localparam logic [PHASE_W-1:0] PH_VALUE        = 5'd17;
    localparam logic [PHASE_W-1:0] PH_LF2          = 5'd18;
    localparam logic [PHASE_W-1:0] PH_LF3          = 5'd19;

    // status codes
    localparam logic [1:0] ST_PENDING = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;

    // byte roles
    localparam logic [2:0] RL_NONE  = 3'd0;
    localparam logic [2:0] RL_METH  = 3'd1;
    localparam logic [2:0] RL_URI   = 3'd2;
    localparam logic [2:0] RL_NAME  = 3'd3;
    localparam logic [2:0] RL_VALUE = 3'd4;

    // characters
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CH_CTL_MAX = 8'h1f;

    localparam logic [15:0] VER_MAX = 16'hffff;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  byte_role;
        logic        header_begins;
        logic [7:0]  echo_byte;
        logic [15:0] major_version;
        logic [15:0] minor_version;
    } hrp_result_t;

    function automatic logic is_ctl(input logic [7:0] b);
        return (b <= CH_CTL_MAX) || (b == CH_DEL);
    endfunction

    function automatic logic is_sep(input logic [7:0] b);
        logic r;
        case (b) inside
            8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a, 8'h5c, 8'h22,
            8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d, 8'h7b, 8'h7d, CH_SP, CH_HT:
                r = 1'b1;
            default:
                r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_token(input logic [7:0] b);
        return !b[7] && !is_ctl(b) && !is_sep(b);
    endfunction

    function automatic logic is_dec(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    // v * 10 + digit, saturating at 16 bits
    function automatic logic [15:0] add_digit(input logic [15:0] v, input logic [7:0] b);
        logic [19:0] r;
        r = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {16'd0, b[3:0]};
        return (r > {4'd0, VER_MAX}) ? VER_MAX : r[15:0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hrp_core.sv @@
// parser state and per-byte next-state / result logic
// depends on hrp_pkg
`default_nettype none

module hrp_core
    import hrp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [7:0]  data_byte,
    input  wire logic        restart,
    output hrp_result_t      result
);

    logic [PHASE_W-1:0] phase_reg, phase_next, phase_cur, nx;
    logic               hdr_seen_reg, hdr_seen_next, hdr_cur;
    logic [15:0]        major_reg, major_next, major_cur;
    logic [15:0]        minor_reg, minor_next, minor_cur;
    logic               bad;
    logic [1:0]         st;
    logic [2:0]         role;
    logic               begins;

    // restart clears the state ahead of this byte
    assign phase_cur = restart ? PH_METHOD_START : phase_reg;
    assign hdr_cur   = restart ? 1'b0 : hdr_seen_reg;
    assign major_cur = restart ? 16'd0 : major_reg;
    assign minor_cur = restart ? 16'd0 : minor_reg;

    always_comb
    begin
        nx            = phase_cur;
        bad           = 1'b0;
        st            = ST_PENDING;
        role          = RL_NONE;
        begins        = 1'b0;
        hdr_seen_next = hdr_cur;
        major_next    = major_cur;
        minor_next    = minor_cur;

        unique case (phase_cur)
            PH_METHOD_START:
                if (is_token(data_byte))
                begin
                    nx   = PH_METHOD;
                    role = RL_METH;
                end
                else bad = 1'b1;
            PH_METHOD:
                if (data_byte == CH_SP) nx = PH_URI;
                else if (is_token(data_byte)) role = RL_METH;
                else bad = 1'b1;
            PH_URI:
                if (data_byte == CH_SP) nx = PH_VER_H;
                else if (is_ctl(data_byte)) bad = 1'b1;
                else role = RL_URI;
            PH_VER_H:
                if (data_byte == CH_H) nx = PH_VER_T1; else bad = 1'b1;
            PH_VER_T1:
                if (data_byte == CH_T) nx = PH_VER_T2; else bad = 1'b1;
            PH_VER_T2:
                if (data_byte == CH_T) nx = PH_VER_P; else bad = 1'b1;
            PH_VER_P:
                if (data_byte == CH_P) nx = PH_VER_SLASH; else bad = 1'b1;
            PH_VER_SLASH:
                if (data_byte == CH_SLASH)
                begin
                    major_next = 16'd0;
                    minor_next = 16'd0;
                    nx         = PH_MAJOR_START;
                end
                else bad = 1'b1;
            PH_MAJOR_START:
                if (is_dec(data_byte))
                begin
                    major_next = add_digit(major_cur, data_byte);
                    nx         = PH_MAJOR;
                end
                else bad = 1'b1;
            PH_MAJOR:
                if (data_byte == CH_DOT) nx = PH_MINOR_START;
                else if (is_dec(data_byte)) major_next = add_digit(major_cur, data_byte);
                else bad = 1'b1;
            PH_MINOR_START:
                if (is_dec(data_byte))
                begin
                    minor_next = add_digit(minor_cur, data_byte);
                    nx         = PH_MINOR;
                end
                else bad = 1'b1;
            PH_MINOR:
                if (data_byte == CH_CR) nx = PH_LF1;
                else if (is_dec(data_byte)) minor_next = add_digit(minor_cur, data_byte);
                else bad = 1'b1;
            PH_LF1:
                if (data_byte == CH_LF) nx = PH_LINE_START; else bad = 1'b1;
            PH_LINE_START:
                if (data_byte == CH_CR) nx = PH_LF3;
                else if (hdr_cur && (data_byte == CH_SP || data_byte == CH_HT)) nx = PH_LWS;
                else if (is_token(data_byte))
                begin
                    hdr_seen_next = 1'b1;
                    begins        = 1'b1;
                    role          = RL_NAME;
                    nx            = PH_NAME;
                end
                else bad = 1'b1;
            PH_LWS:
                if (data_byte == CH_CR) nx = PH_LF2;
                else if (data_byte == CH_SP || data_byte == CH_HT) nx = PH_LWS;
                else if (is_ctl(data_byte)) bad = 1'b1;
                else
                begin
                    nx   = PH_VALUE;
                    role = RL_VALUE;
                end
            PH_NAME:
                if (data_byte == CH_COLON) nx = PH_SPACE_BEFORE;
                else if (is_token(data_byte)) role = RL_NAME;
                else bad = 1'b1;
            PH_SPACE_BEFORE:
                if (data_byte == CH_SP) nx = PH_VALUE; else bad = 1'b1;
            PH_VALUE:
                if (data_byte == CH_CR) nx = PH_LF2;
                else if (is_ctl(data_byte)) bad = 1'b1;
                else role = RL_VALUE;
            PH_LF2:
                if (data_byte == CH_LF) nx = PH_LINE_START; else bad = 1'b1;
            PH_LF3:
                if (data_byte == CH_LF) st = ST_DONE; else bad = 1'b1;
            default:
                bad = 1'b1;
        endcase

        // a rejected byte holds the phase
        if (bad)
        begin
            st     = ST_BAD;
            role   = RL_NONE;
            begins = 1'b0;
        end
        phase_next = bad ? phase_cur : nx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_METHOD_START;
            hdr_seen_reg <= 1'b0;
            major_reg    <= 16'd0;
            minor_reg    <= 16'd0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            hdr_seen_reg <= hdr_seen_next;
            major_reg    <= major_next;
            minor_reg    <= minor_next;
        end
    end

    assign result.status        = st;
    assign result.byte_role     = role;
    assign result.header_begins = begins;
    assign result.echo_byte     = data_byte;
    assign result.major_version = major_next;
    assign result.minor_version = minor_next;

endmodule

`default_nettype wire

@@ hw/rtl/http_request_head_parser.sv @@
// top level of the http request head parser: stream ports, input and result registers
// depends on hrp_pkg and hrp_core
//
// usage:
//   s_* carries one request byte per word; s_tuser[0] is the restart flag,
//   which returns the parser to method start before that byte is parsed.
//   m_* returns exactly one result word per input word, in order: status,
//   byte role and header-begin flag in m_tuser, the echoed byte and the
//   running major/minor version counts in m_tdata.
//   two register stages lie between s_* and m_*: input register, result register.
//   throughput: one word per cycle while m_* is not stalled.
//   when m_tready is low the result register holds and the input register
//   still takes one more word; then s_tready drops until the stall clears.
//   reset clears the parser to method start, the header flag and both
//   version counts, and empties both register stages.
`default_nettype none

module http_request_head_parser
    import hrp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_tuser,   // [0] restart
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [7:0] echo_byte, [23:8] major_version, [39:24] minor_version
    output logic [5:0]       m_tuser    // [1:0] status, [4:2] byte_role, [5] header_begins
);

    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        restart_reg;
    logic        out_valid_reg;
    hrp_result_t res_reg;
    hrp_result_t res;
    logic        advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg    <= s_tdata;
            restart_reg <= s_tuser[0];
        end
        if (advance)
            res_reg <= res;
    end

    hrp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (byte_reg),
        .restart   (restart_reg),
        .result    (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {res_reg.minor_version, res_reg.major_version, res_reg.echo_byte};
    assign m_tuser  = {res_reg.header_begins, res_reg.byte_role, res_reg.status};

    // a rejected word never carries a role
    a_bad_no_role: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1:0] == ST_BAD) |-> (m_tuser[4:2] == RL_NONE && !m_tuser[5]))
        else $error("malformed result carries a role");

    // a new header starts on a name byte while the head is still pending
    a_begin_is_name: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[5]) |-> (m_tuser[4:2] == RL_NAME && m_tuser[1:0] == ST_PENDING))
        else $error("header begin without name role");

    // completion only on the final line feed
    a_done_on_lf: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1:0] == ST_DONE) |-> (m_tdata[7:0] == CH_LF))
        else $error("completion on a byte other than line feed");

    // a waiting word moves on whenever the result slot is free
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("pending word not moved to the result register");

endmodule

`default_nettype wire

@@ test/tb_http_request_head_parser.sv @@
// testbench for http_request_head_parser: random and directed request heads, per-byte verdict check
// depends on hrp_pkg and http_request_head_parser; self-contained otherwise
`timescale 1ns / 100ps

module tb_http_request_head_parser;
    import hrp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int BYTES_PER_PHASE = 300;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } req_word_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [5:0]  m_tuser;

    // bytes waiting to go out, and per-byte verdicts waiting to come back
    req_word_t   request_bytes[$];
    hrp_result_t byte_verdicts[$];
    req_word_t   next_word;

    // parser state as the block should hold it
    logic [PHASE_W-1:0] prs_phase = PH_METHOD_START;
    logic               prs_hdr_seen = 1'b0;
    logic [15:0]        prs_major = '0;
    logic [15:0]        prs_minor = '0;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int noise_permil = 20;
    int src_idle_by_phase[4] = '{0, 65, 0, 17};
    int sink_stall_by_phase[4] = '{0, 0, 65, 17};

    int mismatch_count = 0;
    int bytes_taken = 0;
    int results_seen = 0;
    int heads_done = 0;
    int bytes_malformed = 0;
    int idle_cycles = 0;

    http_request_head_parser i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // byte classes
    function automatic logic ctl_byte(input logic [7:0] b);
        return (b < 8'd32) || (b == 8'd127);
    endfunction

    function automatic logic sep_byte(input logic [7:0] b);
        logic r;
        case (b)
            "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?", "=",
            "{", "}", " ", "\t":
                r = 1'b1;
            default:
                r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic token_byte(input logic [7:0] b);
        return (b < 8'd128) && !ctl_byte(b) && !sep_byte(b);
    endfunction

    function automatic logic digit_byte(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic [15:0] ver_step(input logic [15:0] v, input logic [7:0] b);
        int unsigned r;
        r = v * 10 + (b - 8'h30);
        return (r > 65535) ? 16'hffff : r[15:0];
    endfunction

    // one byte through the parser: update state, queue the verdict
    task automatic parse_head_byte(input logic [7:0] b, input logic rs);
        logic [PHASE_W-1:0] nxt;
        logic               bad;
        hrp_result_t        v;
        if (rs)
        begin
            prs_phase = PH_METHOD_START;
            prs_hdr_seen = 1'b0;
            prs_major = '0;
            prs_minor = '0;
        end
        v.status = ST_PENDING;
        v.byte_role = RL_NONE;
        v.header_begins = 1'b0;
        v.echo_byte = b;
        nxt = prs_phase;
        bad = 1'b0;
        case (prs_phase)
            PH_METHOD_START:
                if (token_byte(b))
                begin
                    nxt = PH_METHOD;
                    v.byte_role = RL_METH;
                end
                else bad = 1'b1;
            PH_METHOD:
                if (b == CH_SP) nxt = PH_URI;
                else if (token_byte(b)) v.byte_role = RL_METH;
                else bad = 1'b1;
            PH_URI:
                if (b == CH_SP) nxt = PH_VER_H;
                else if (ctl_byte(b)) bad = 1'b1;
                else v.byte_role = RL_URI;
            PH_VER_H:  if (b == "H") nxt = PH_VER_T1; else bad = 1'b1;
            PH_VER_T1: if (b == "T") nxt = PH_VER_T2; else bad = 1'b1;
            PH_VER_T2: if (b == "T") nxt = PH_VER_P; else bad = 1'b1;
            PH_VER_P:  if (b == "P") nxt = PH_VER_SLASH; else bad = 1'b1;
            PH_VER_SLASH:
                if (b == "/")
                begin
                    prs_major = '0;
                    prs_minor = '0;
                    nxt = PH_MAJOR_START;
                end
                else bad = 1'b1;
            PH_MAJOR_START:
                if (digit_byte(b))
                begin
                    prs_major = ver_step(prs_major, b);
                    nxt = PH_MAJOR;
                end
                else bad = 1'b1;
            PH_MAJOR:
                if (b == ".") nxt = PH_MINOR_START;
                else if (digit_byte(b)) prs_major = ver_step(prs_major, b);
                else bad = 1'b1;
            PH_MINOR_START:
                if (digit_byte(b))
                begin
                    prs_minor = ver_step(prs_minor, b);
                    nxt = PH_MINOR;
                end
                else bad = 1'b1;
            PH_MINOR:
                if (b == CH_CR) nxt = PH_LF1;
                else if (digit_byte(b)) prs_minor = ver_step(prs_minor, b);
                else bad = 1'b1;
            PH_LF1:
                if (b == CH_LF) nxt = PH_LINE_START; else bad = 1'b1;
            PH_LINE_START:
                if (b == CH_CR) nxt = PH_LF3;
                else if (prs_hdr_seen && (b == CH_SP || b == CH_HT)) nxt = PH_LWS;
                else if (token_byte(b))
                begin
                    prs_hdr_seen = 1'b1;
                    v.header_begins = 1'b1;
                    v.byte_role = RL_NAME;
                    nxt = PH_NAME;
                end
                else bad = 1'b1;
            PH_LWS:
                if (b == CH_CR) nxt = PH_LF2;
                else if (b == CH_SP || b == CH_HT) nxt = PH_LWS;
                else if (ctl_byte(b)) bad = 1'b1;
                else
                begin
                    nxt = PH_VALUE;
                    v.byte_role = RL_VALUE;
                end
            PH_NAME:
                if (b == ":") nxt = PH_SPACE_BEFORE;
                else if (token_byte(b)) v.byte_role = RL_NAME;
                else bad = 1'b1;
            PH_SPACE_BEFORE:
                if (b == CH_SP) nxt = PH_VALUE; else bad = 1'b1;
            PH_VALUE:
                if (b == CH_CR) nxt = PH_LF2;
                else if (ctl_byte(b)) bad = 1'b1;
                else v.byte_role = RL_VALUE;
            PH_LF2:
                if (b == CH_LF) nxt = PH_LINE_START; else bad = 1'b1;
            PH_LF3:
                if (b == CH_LF) v.status = ST_DONE; else bad = 1'b1;
            default:
                bad = 1'b1;
        endcase
        if (bad)
        begin
            v.status = ST_BAD;
            v.byte_role = RL_NONE;
            v.header_begins = 1'b0;
        end
        else prs_phase = nxt;
        v.major_version = prs_major;
        v.minor_version = prs_minor;
        byte_verdicts.insert(byte_verdicts.size(), v);
    endtask

    // stimulus helpers
    task automatic push_word(input logic [7:0] b, input logic rs);
        req_word_t w;
        w.data_byte = b;
        w.restart = rs;
        request_bytes.insert(request_bytes.size(), w);
    endtask

    // occasionally slip a stray byte in front of the intended one
    task automatic push_noisy(input logic [7:0] b, input logic rs);
        if ($urandom_range(999) < noise_permil)
            push_word(8'($urandom_range(255)), $urandom_range(31) == 0);
        push_word(b, rs);
    endtask

    task automatic push_text(input string s, input bit noisy);
        foreach (s[i])
            if (noisy) push_noisy(s[i], 1'b0);
            else push_word(s[i], 1'b0);
    endtask

    function automatic logic [7:0] pick_token();
        logic [7:0] b;
        do b = 8'($urandom_range(33, 126)); while (!token_byte(b));
        return b;
    endfunction

    // printable or high byte, never a control byte
    function automatic logic [7:0] pick_text(input bit allow_space);
        logic [7:0] b;
        case ($urandom_range(9))
            0: b = 8'($urandom_range(128, 255));
            1: b = allow_space ? CH_SP : 8'h21;
            default: b = 8'($urandom_range(33, 126));
        endcase
        return b;
    endfunction

    task automatic push_version_number();
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(5, 8) : 1;
        repeat (n) push_noisy(8'(CH_ZERO + $urandom_range(9)), 1'b0);
    endtask

    // one mostly well-formed request head with random content
    task automatic queue_request();
        int n;
        push_noisy(pick_token(), $urandom_range(9) != 0);
        repeat ($urandom_range(0, 5)) push_noisy(pick_token(), 1'b0);
        push_noisy(CH_SP, 1'b0);
        repeat ($urandom_range(1, 10)) push_noisy(pick_text(1'b0), 1'b0);
        push_noisy(CH_SP, 1'b0);
        push_text("HTTP/", 1'b1);
        push_version_number();
        push_noisy(CH_DOT, 1'b0);
        push_version_number();
        push_text("\015\n", 1'b1);
        // folded line before any header is refused
        if ($urandom_range(7) == 0)
            push_noisy($urandom_range(1) ? CH_SP : CH_HT, 1'b0);
        repeat ($urandom_range(0, 4))
        begin
            repeat ($urandom_range(1, 8)) push_noisy(pick_token(), 1'b0);
            push_text(": ", 1'b1);
            repeat ($urandom_range(0, 10)) push_noisy(pick_text(1'b1), 1'b0);
            push_text("\015\n", 1'b1);
            if ($urandom_range(3) == 0)
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                begin
                    repeat ($urandom_range(1, 3)) push_noisy($urandom_range(1) ? CH_SP : CH_HT, 1'b0);
                    if ($urandom_range(1))
                        repeat ($urandom_range(1, 6)) push_noisy(pick_text(1'b1), 1'b0);
                    push_text("\015\n", 1'b1);
                end
            end
        end
        push_text("\015\n", 1'b1);
        case ($urandom_range(5))
            0: repeat ($urandom_range(1, 2)) push_word(CH_LF, 1'b0);
            1: push_word(8'($urandom_range(255)), 1'b0);
            default: ;
        endcase
    endtask

    task automatic check_result(input hrp_result_t got);
        hrp_result_t want;
        if (byte_verdicts.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected word: status=%0d role=%0d begins=%0d byte=%02h maj=%0d min=%0d",
                         got.status, got.byte_role, got.header_begins, got.echo_byte,
                         got.major_version, got.minor_version);
            return;
        end
        want = byte_verdicts.pop_front();
        if (want.status == ST_DONE) heads_done++;
        if (want.status == ST_BAD) bytes_malformed++;
        if (got.status !== want.status || got.byte_role !== want.byte_role ||
            got.header_begins !== want.header_begins || got.echo_byte !== want.echo_byte ||
            got.major_version !== want.major_version ||
            got.minor_version !== want.minor_version)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
            begin
                $display("mismatch at result %0d, byte %02h", results_seen, want.echo_byte);
                $display("  exp status=%0d role=%0d begins=%0d byte=%02h maj=%0d min=%0d",
                         want.status, want.byte_role, want.header_begins, want.echo_byte,
                         want.major_version, want.minor_version);
                $display("  got status=%0d role=%0d begins=%0d byte=%02h maj=%0d min=%0d",
                         got.status, got.byte_role, got.header_begins, got.echo_byte,
                         got.major_version, got.minor_version);
            end
        end
    endtask

    // driver: predicts each word as it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                parse_head_byte(s_tdata, s_tuser[0]);
                bytes_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (request_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    next_word = request_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= next_word.data_byte;
                    s_tuser <= next_word.restart;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            check_result('{status: m_tuser[1:0], byte_role: m_tuser[4:2],
                           header_begins: m_tuser[5], echo_byte: m_tdata[7:0],
                           major_version: m_tdata[23:8], minor_version: m_tdata[39:24]});
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles, %0d verdicts outstanding",
                         idle_cycles, byte_verdicts.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: high byte and restart at method start, high byte in uri, extreme
        // digits, folded line before any header, empty value, folded empty line,
        // repeated final line feed, byte after completion
        push_word(8'hff, 1'b1);
        push_text("G ", 1'b0);
        push_word(8'hff, 1'b0);
        push_text(" HTTP/9.0\015\n X: \015\n\t\015\n\015\n\nA", 1'b0);

        for (int p = 0; p < 4; p++)
        begin
            @(negedge clk);
            src_idle_pct = src_idle_by_phase[p];
            sink_stall_pct = sink_stall_by_phase[p];
            while (request_bytes.size() < BYTES_PER_PHASE)
            begin
                if ($urandom_range(9) == 0)
                    repeat ($urandom_range(5, 15))
                        push_word(8'($urandom_range(255)), $urandom_range(7) == 0);
                else
                    queue_request();
            end
            // hold off until every verdict of this phase is back
            while (request_bytes.size() != 0 || s_tvalid || byte_verdicts.size() != 0)
                @(negedge clk);
        end

        repeat (4) @(posedge clk);
        $display("run covered %0d bytes in four idle/stall phases: %0d heads completed, %0d bytes malformed",
                 bytes_taken, heads_done, bytes_malformed);
        if (mismatch_count == 0 && byte_verdicts.size() == 0 && results_seen == bytes_taken)
            $display("tb: success");
        else
        begin
            $display("%0d mismatches, %0d verdicts left over", mismatch_count, byte_verdicts.size());
            $display("tb: failure");
        end
        $finish;
    end

endmodule
